// ===== design/area_average_downscale_macros.svh =====
// assertion macros used by the checker file
`ifndef AREA_AVERAGE_DOWNSCALE_MACROS_SVH
`define AREA_AVERAGE_DOWNSCALE_MACROS_SVH

// same-cycle implication, reset-qualified
`define AAD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled during reset too
`define AAD_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/aad_pkg.sv =====
// types and constants of the area-average downscaler
package aad_pkg;

  localparam int CFG_W    = 11;
  localparam int PIX_W    = 8;
  localparam int OROW_W   = 10;
  localparam int OCOL_W   = 8;

  localparam logic [CFG_W-1:0] RST_IN_ROWS  = 11'd512;
  localparam logic [CFG_W-1:0] RST_IN_COLS  = 11'd512;
  localparam logic [CFG_W-1:0] RST_OUT_ROWS = 11'd64;
  localparam logic [8:0]       RST_OUT_COLS = 9'd64;

  typedef enum logic [1:0] {
    REG_IN_ROWS  = 2'd0,
    REG_IN_COLS  = 2'd1,
    REG_OUT_ROWS = 2'd2,
    REG_OUT_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_COLS = 2'd0,
    DIV_ROWS = 2'd1,
    DIV_SEG  = 2'd2,
    DIV_OUT  = 2'd3
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_CLAMP,
    ST_DIVC,
    ST_WAITC,
    ST_DIVR,
    ST_WAITR,
    ST_IDLE,
    ST_DIVS,
    ST_WAITS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_DIVO,
    ST_WAITO,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load_sizes;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_col_bins;
    logic     store_row_bins;
    logic     take_pixel;
    logic     acc_read;
    logic     acc_write;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic bin_end;
    logic last_row;
    logic out_free;
  } status_t;

endpackage

// ===== design/aad_pix_if.sv =====
// pixel request channel
interface aad_pix_if;
  logic                      valid;
  logic                      ready;
  logic [aad_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ===== design/aad_res_if.sv =====
// reduced pixel request channel
interface aad_res_if;
  logic                       valid;
  logic                       ready;
  logic [aad_pkg::PIX_W-1:0]  out_pixel;
  logic [aad_pkg::OROW_W-1:0] out_row;
  logic [aad_pkg::OCOL_W-1:0] out_col;
  logic                       last_of_frame;

  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink (input valid, input out_pixel, input out_row, input out_col,
                input last_of_frame, output ready);
endinterface

// ===== design/area_average_downscale.sv =====
// top level of the area-average downscaler
// Reduces a grey frame streamed in raster order to out_rows x out_cols by
// averaging each block of input pixels (row-segment averages floored, then
// their mean over the row bin floored).
// Channels: pix_in takes one 8-bit pixel per request; res_out gives one
// reduced pixel with its row, column and a last-of-frame flag. cfg_we,
// cfg_index and cfg_data write the four size registers; any write restarts
// the frame and the bin split is recomputed.
// Stalls: a pixel inside a column bin is taken without a stall; a pixel that
// closes a column bin stalls the input while its segment average is divided
// and added into the accumulator memory, and one that closes a whole block
// also while the block average is divided and handed to the output register.
// The single shared divider, one quotient bit per cycle, sets these stalls.
// After reset or a register write, no pixel is taken until the column and
// row bin splits have been divided out. The result sits in an output register:
// the next pixels are taken while it waits, and only the next result waits for it to leave.
module area_average_downscale #(
  parameter int MAX_IN_ROWS  = 1024,
  parameter int MAX_IN_COLS  = 1024,
  parameter int MAX_OUT_COLS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  aad_pkg::cfg_reg_t         cfg_index,
  input  logic [aad_pkg::CFG_W-1:0] cfg_data,
  aad_pix_if.sink                   pix_in,
  aad_res_if.source                 res_out
);
  import aad_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    pix_ready;

  aad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .pix_valid (pix_in.valid),
    .pix_ready (pix_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assign pix_in.ready = pix_ready;

  aad_dp #(
    .MAX_IN_ROWS  (MAX_IN_ROWS),
    .MAX_IN_COLS  (MAX_IN_COLS),
    .MAX_OUT_COLS (MAX_OUT_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix_in.pixel),
    .cmd       (cmd),
    .status    (status),
    .res_out   (res_out)
  );
endmodule

// ===== design/aad_div.sv =====
// restoring divider, one quotient bit per cycle
module aad_div #(
  parameter int DW = 18,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic          done
);
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem, dvd[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(DW);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? VW'(rem_sh - {1'b0, dsr}) : rem_sh[VW-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;
endmodule

// ===== design/aad_dp.sv =====
// datapath: sizes, bin counters, accumulator memory, divider and output register
module aad_dp #(
  parameter int MAX_IN_ROWS  = 1024,
  parameter int MAX_IN_COLS  = 1024,
  parameter int MAX_OUT_COLS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  aad_pkg::cfg_reg_t                 cfg_index,
  input  logic [aad_pkg::CFG_W-1:0]         cfg_data,
  input  logic [aad_pkg::PIX_W-1:0]         pixel,
  input  aad_pkg::cmd_t                     cmd,
  output aad_pkg::status_t                  status,
  aad_res_if.source                         res_out
);
  import aad_pkg::*;

  localparam int RW  = $clog2(MAX_IN_ROWS + 1);
  localparam int CW  = $clog2(MAX_IN_COLS + 1);
  localparam int OCW = $clog2(MAX_OUT_COLS + 1);
  localparam int BW  = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int SW  = PIX_W + CW;
  localparam int AW  = PIX_W + RW;
  localparam int DW  = (SW > AW) ? SW : AW;
  localparam int VW  = (RW > CW) ? RW : CW;

  // configuration registers
  logic [CFG_W-1:0] in_rows, in_cols, out_rows;
  logic [8:0]       out_cols;

  // clamped sizes and bin quotients
  logic [RW-1:0]  nr, mr, qr, rr;
  logic [CW-1:0]  nc, qc;
  logic [OCW-1:0] mc, rc;
  logic [RW-1:0]  nr_next, mr_next;
  logic [CW-1:0]  nc_next;
  logic [OCW-1:0] mc_next;
  logic [CW-1:0]  mc_hi;

  // position state
  logic [RW-1:0] row_count, row_bin_index, pos_in_row_bin;
  logic [CW-1:0] col_count, pos_in_col_bin;
  logic [BW-1:0] col_bin_index;
  logic [SW-1:0] segment_sum;

  // captured for the running bin
  logic [SW-1:0] seg_total;
  logic [CW-1:0] colw_r;
  logic [RW-1:0] roww_r, rbi_r;
  logic [BW-1:0] ci_r;
  logic          first_row, last_row, last_frame;

  logic [CW-1:0] colw;
  logic [RW-1:0] roww;
  logic [SW-1:0] sum_next;

  logic [AW-1:0] acc_mem [MAX_OUT_COLS];
  logic [AW-1:0] acc_rd, acc_new, acc_sum;

  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_q;
  logic [VW-1:0] div_divisor, div_r;

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rows  <= RST_IN_ROWS;
      in_cols  <= RST_IN_COLS;
      out_rows <= RST_OUT_ROWS;
      out_cols <= RST_OUT_COLS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_ROWS:  in_rows  <= cfg_data;
        REG_IN_COLS:  in_cols  <= cfg_data;
        REG_OUT_ROWS: out_rows <= cfg_data;
        REG_OUT_COLS: out_cols <= cfg_data[8:0];
        default:      in_rows  <= in_rows;
      endcase
    end
  end

  // zero counts as one, large values clamp to the limit
  always_comb begin
    if (in_rows == '0) nr_next = RW'(1);
    else if (int'(in_rows) > MAX_IN_ROWS) nr_next = RW'(MAX_IN_ROWS);
    else nr_next = RW'(in_rows);
    if (in_cols == '0) nc_next = CW'(1);
    else if (int'(in_cols) > MAX_IN_COLS) nc_next = CW'(MAX_IN_COLS);
    else nc_next = CW'(in_cols);
    if (out_rows == '0) mr_next = RW'(1);
    else if (int'(out_rows) > int'(nr_next)) mr_next = nr_next;
    else mr_next = RW'(out_rows);
    mc_hi = (int'(nc_next) < MAX_OUT_COLS) ? nc_next : CW'(MAX_OUT_COLS);
    if (out_cols == '0) mc_next = OCW'(1);
    else if (int'(out_cols) > int'(mc_hi)) mc_next = OCW'(mc_hi);
    else mc_next = OCW'(out_cols);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sizes) begin
      nr <= nr_next;
      nc <= nc_next;
      mr <= mr_next;
      mc <= mc_next;
    end
    if (cmd.store_col_bins) begin
      qc <= CW'(div_q);
      rc <= OCW'(div_r);
    end
    if (cmd.store_row_bins) begin
      qr <= RW'(div_q);
      rr <= RW'(div_r);
    end
  end

  assign colw     = qc + CW'(int'(col_bin_index) < int'(rc));
  assign roww     = qr + RW'(row_bin_index < rr);
  assign sum_next = segment_sum + SW'(pixel);

  assign status.bin_end  = (pos_in_col_bin + CW'(1)) >= colw;
  assign status.last_row = last_row;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_count      <= '0;
      col_count      <= '0;
      col_bin_index  <= '0;
      pos_in_col_bin <= '0;
      row_bin_index  <= '0;
      pos_in_row_bin <= '0;
      segment_sum    <= '0;
    end else if (cmd.take_pixel) begin
      if (status.bin_end) begin
        segment_sum    <= '0;
        pos_in_col_bin <= '0;
        col_bin_index  <= col_bin_index + BW'(1);
      end else begin
        segment_sum    <= sum_next;
        pos_in_col_bin <= pos_in_col_bin + CW'(1);
      end
      if ((col_count + CW'(1)) >= nc) begin
        col_count      <= '0;
        col_bin_index  <= '0;
        pos_in_col_bin <= '0;
        segment_sum    <= '0;
        if ((pos_in_row_bin + RW'(1)) >= roww) begin
          pos_in_row_bin <= '0;
          row_bin_index  <= row_bin_index + RW'(1);
        end else begin
          pos_in_row_bin <= pos_in_row_bin + RW'(1);
        end
        if ((row_count + RW'(1)) >= nr) begin
          row_count      <= '0;
          row_bin_index  <= '0;
          pos_in_row_bin <= '0;
        end else begin
          row_count <= row_count + RW'(1);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      seg_total  <= sum_next;
      colw_r     <= colw;
      roww_r     <= roww;
      ci_r       <= col_bin_index;
      rbi_r      <= row_bin_index;
      first_row  <= (pos_in_row_bin == '0);
      last_row   <= (pos_in_row_bin + RW'(1)) >= roww;
      last_frame <= (row_bin_index == (mr - RW'(1)))
                    && (int'(col_bin_index) == int'(mc) - 1);
    end
  end

  // accumulator memory, restarted on a bin's first row and added to on its other rows
  assign acc_sum = first_row ? AW'(div_q) : acc_rd + AW'(div_q);

  always_ff @(posedge clk) begin
    if (cmd.acc_read) begin
      acc_rd <= acc_mem[ci_r];
    end
    if (cmd.acc_write) begin
      acc_mem[ci_r] <= acc_sum;
      acc_new       <= acc_sum;
    end
  end

  assign div_start = cmd.div_start;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_COLS: begin
        div_dividend = DW'(nc);
        div_divisor  = VW'(mc);
      end
      DIV_ROWS: begin
        div_dividend = DW'(nr);
        div_divisor  = VW'(mr);
      end
      DIV_SEG: begin
        div_dividend = DW'(seg_total);
        div_divisor  = VW'(colw_r);
      end
      DIV_OUT: begin
        div_dividend = DW'(acc_new);
        div_divisor  = VW'(roww_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = VW'(1);
      end
    endcase
  end

  aad_div #(.DW(DW), .VW(VW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_out.out_pixel     <= div_q[PIX_W-1:0];
      res_out.out_row       <= OROW_W'(rbi_r);
      res_out.out_col       <= OCOL_W'(ci_r);
      res_out.last_of_frame <= last_frame;
    end
  end

  assign res_out.valid = out_valid;
endmodule

// ===== design/aad_ctrl.sv =====
// controller: sequences setup divisions and per-bin work
module aad_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  aad_pkg::status_t status,
  output aad_pkg::cmd_t    cmd
);
  import aad_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLAMP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_COLS;
    pix_ready  = 1'b0;
    unique case (state)
      ST_CLAMP: begin
        cmd.load_sizes = 1'b1;
        state_next     = ST_DIVC;
      end
      ST_DIVC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COLS;
        state_next    = ST_WAITC;
      end
      ST_WAITC: begin
        if (status.div_done) begin
          cmd.store_col_bins = 1'b1;
          state_next         = ST_DIVR;
        end
      end
      ST_DIVR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROWS;
        state_next    = ST_WAITR;
      end
      ST_WAITR: begin
        if (status.div_done) begin
          cmd.store_row_bins = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.take_pixel = 1'b1;
          if (status.bin_end) state_next = ST_DIVS;
        end
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEG;
        state_next    = ST_WAITS;
      end
      ST_WAITS: begin
        if (status.div_done) begin
          cmd.acc_read = 1'b1;
          state_next   = ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.acc_write = 1'b1;
        state_next    = status.last_row ? ST_DIVO : ST_IDLE;
      end
      ST_DIVO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OUT;
        state_next    = ST_WAITO;
      end
      ST_WAITO: begin
        if (status.div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLAMP;
    endcase
    // new sizes: recompute the bin split
    if (cfg_we) begin
      state_next = ST_CLAMP;
    end
  end
endmodule

// ===== design/aad_check.sv =====
// port-level checks of the downscaler, bound to the top level
`include "area_average_downscale_macros.svh"

module aad_check (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_last
);
  // a size change blocks input while the bins are recomputed
  `AAD_ASSERT_NEXT(a_cfg_blocks_input, clk, cfg_we, !pix_ready)
  // nothing is waiting right after reset
  `AAD_ASSERT_NEXT(a_rst_clears_out, clk, rst, !res_valid && !pix_ready)
  // a stalled result stays offered
  `AAD_ASSERT_NOW(a_res_holds, clk, rst, $past(res_valid && !res_ready) && !$past(rst),
                  res_valid && $stable(res_last))
endmodule

bind area_average_downscale aad_check u_check (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .pix_valid (pix_in.valid),
  .pix_ready (pix_in.ready),
  .res_valid (res_out.valid),
  .res_ready (res_out.ready),
  .res_last  (res_out.last_of_frame)
);
